FILE: hdl/derq_pkg.sv
// Package of shared types and codes for the deduplicating event report queue.
`timescale 1ns / 1ps

package derq_pkg;

    localparam int ID_W     = 16;
    localparam int STATUS_W = 8;
    localparam int OCC_W    = 4;

    // Operation code of an input word
    typedef enum logic {
        KIND_PUSH = 1'b0,
        KIND_POP  = 1'b1
    } kind_t;

    // Push outcome reported with every result word
    typedef enum logic [1:0] {
        OUT_STORED = 2'd0,
        OUT_DUP    = 2'd1,
        OUT_FULL   = 2'd2,
        OUT_NONE   = 2'd3
    } outcome_t;

endpackage

FILE: hdl/derq_in_if.sv
// Channel interfaces for operation words in and result words out.
`timescale 1ns / 1ps

interface derq_in_if import derq_pkg::*; ();
    logic                valid;
    logic                ready;
    logic                kind;
    logic [ID_W-1:0]     event_id;
    logic [STATUS_W-1:0] event_status;

    modport source (output valid, output kind, output event_id, output event_status,
                    input ready);
    modport sink   (input valid, input kind, input event_id, input event_status,
                    output ready);
endinterface

interface derq_out_if import derq_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [1:0]          push_outcome;
    logic                pop_valid;
    logic [ID_W-1:0]     out_event_id;
    logic [STATUS_W-1:0] out_event_status;
    logic [OCC_W-1:0]    occupancy;

    modport source (output valid, output push_outcome, output pop_valid,
                    output out_event_id, output out_event_status, output occupancy,
                    input ready);
    modport sink   (input valid, input push_outcome, input pop_valid,
                    input out_event_id, input out_event_status, input occupancy,
                    output ready);
endinterface

FILE: hdl/dedup_event_report_queue_core.sv
// Top level: ordered event report queue that drops duplicate ids and pushes when full.
// An accepted word waits in the input register until the result register is free to take it.
// Throughput: one word per clock while results are taken; input and result registers form a
//   two-stage pipeline with the queue update (parallel id compare, shift or append) between.
// Reset (rst_n low, asynchronous): queue empty, both pipeline stages empty.
// Queue entries are not cleared; only slots below the occupancy count are ever read.
`timescale 1ns / 1ps

module dedup_event_report_queue_core
    import derq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    derq_in_if.sink     evt_in,
    derq_out_if.source  rpt_out
);

    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int IW = $clog2(QUEUE_DEPTH);

    // Input stage
    logic                in_valid_reg;
    logic                kind_reg;
    logic [ID_W-1:0]     id_reg;
    logic [STATUS_W-1:0] status_reg;

    // Queue storage
    logic [ID_W-1:0]     ids_reg    [QUEUE_DEPTH];
    logic [STATUS_W-1:0] stats_reg  [QUEUE_DEPTH];
    logic [ID_W-1:0]     ids_next   [QUEUE_DEPTH];
    logic [STATUS_W-1:0] stats_next [QUEUE_DEPTH];
    logic [CW-1:0]       count_reg;
    logic [CW-1:0]       count_next;

    // Result stage
    logic                res_valid_reg;
    outcome_t            outcome_reg;
    outcome_t            outcome_next;
    logic                pop_valid_reg;
    logic                pop_valid_next;
    logic [ID_W-1:0]     oid_reg;
    logic [ID_W-1:0]     oid_next;
    logic [STATUS_W-1:0] ostat_reg;
    logic [STATUS_W-1:0] ostat_next;
    logic [OCC_W-1:0]    occ_reg;

    logic                out_free;
    logic                fire;
    logic                in_take;
    logic [QUEUE_DEPTH-1:0] hit_vec;
    logic                dup;
    logic                full;

    assign out_free = !res_valid_reg || rpt_out.ready;
    assign fire     = in_valid_reg && out_free;
    assign evt_in.ready = !in_valid_reg || out_free;
    assign in_take  = evt_in.valid && evt_in.ready;

    // Compare the id against every occupied slot
    always_comb
    begin
        for (int k = 0; k < QUEUE_DEPTH; k++)
        begin
            hit_vec[k] = (ids_reg[k] == id_reg) && (CW'(k) < count_reg);
        end
    end

    assign dup  = |hit_vec;
    assign full = (count_reg == CW'(QUEUE_DEPTH));

    // Work out the queue update and the result word
    always_comb
    begin
        for (int k = 0; k < QUEUE_DEPTH; k++)
        begin
            ids_next[k]   = ids_reg[k];
            stats_next[k] = stats_reg[k];
        end
        count_next     = count_reg;
        outcome_next   = OUT_NONE;
        pop_valid_next = 1'b0;
        oid_next       = '0;
        ostat_next     = '0;
        case (kind_reg)
            KIND_PUSH:
            begin
                if (dup)
                begin
                    outcome_next = OUT_DUP;
                end
                else if (full)
                begin
                    outcome_next = OUT_FULL;
                end
                else
                begin
                    ids_next[count_reg[IW-1:0]]   = id_reg;
                    stats_next[count_reg[IW-1:0]] = status_reg;
                    count_next   = count_reg + 1'b1;
                    outcome_next = OUT_STORED;
                end
            end
            KIND_POP:
            begin
                if (count_reg != '0)
                begin
                    pop_valid_next = 1'b1;
                    oid_next       = ids_reg[0];
                    ostat_next     = stats_reg[0];
                    // advance every entry one slot toward the head
                    for (int k = 0; k < QUEUE_DEPTH - 1; k++)
                    begin
                        ids_next[k]   = ids_reg[k + 1];
                        stats_next[k] = stats_reg[k + 1];
                    end
                    count_next = count_reg - 1'b1;
                end
            end
            default:
            begin
                outcome_next = OUT_NONE;
            end
        endcase
    end

    // Control registers: stage valids and occupancy count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
            count_reg     <= '0;
        end
        else
        begin
            if (in_take)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (fire)
            begin
                in_valid_reg <= 1'b0;
            end
            if (fire)
            begin
                res_valid_reg <= 1'b1;
                count_reg     <= count_next;
            end
            else if (rpt_out.ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers: capture input word, queue entries and result word
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            kind_reg   <= evt_in.kind;
            id_reg     <= evt_in.event_id;
            status_reg <= evt_in.event_status;
        end
        if (fire)
        begin
            for (int k = 0; k < QUEUE_DEPTH; k++)
            begin
                ids_reg[k]   <= ids_next[k];
                stats_reg[k] <= stats_next[k];
            end
            outcome_reg   <= outcome_next;
            pop_valid_reg <= pop_valid_next;
            oid_reg       <= oid_next;
            ostat_reg     <= ostat_next;
            occ_reg       <= OCC_W'(count_next);
        end
    end

    assign rpt_out.valid            = res_valid_reg;
    assign rpt_out.push_outcome     = outcome_reg;
    assign rpt_out.pop_valid        = pop_valid_reg;
    assign rpt_out.out_event_id     = oid_reg;
    assign rpt_out.out_event_status = ostat_reg;
    assign rpt_out.occupancy        = occ_reg;

`ifndef SYNTH
    // Count never runs past the queue depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(QUEUE_DEPTH))
        else $error("occupancy count exceeds queue depth");

    // A stored push grows the queue by exactly one
    a_store_grows: assert property (@(posedge clk) disable iff (!rst_n)
        fire && (outcome_next == OUT_STORED) |=> count_reg == $past(count_reg) + 1'b1)
        else $error("stored push did not grow the queue by one");

    // A full drop only happens with every slot occupied
    a_full_drop: assert property (@(posedge clk) disable iff (!rst_n)
        fire && (outcome_next == OUT_FULL) |-> full && !dup)
        else $error("full drop reported with a free slot");

    // A pop on an empty queue leaves it empty
    a_empty_pop: assert property (@(posedge clk) disable iff (!rst_n)
        fire && (kind_reg == KIND_POP) && (count_reg == '0) |=> count_reg == '0)
        else $error("pop on empty queue changed the count");

    // A returned entry is never paired with a push outcome
    a_pop_outcome: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && pop_valid_reg |-> outcome_reg == OUT_NONE)
        else $error("popped entry reported with a push outcome");
`endif

endmodule

FILE: verif/dedup_event_report_queue_core_test.sv
// Self-checking testbench for the deduplicating event report queue core.
`timescale 1ns / 1ps

module dedup_event_report_queue_core_test;
    import derq_pkg::*;

    localparam int QDEPTH = 8;
    localparam int MAX_PRINTS = 40;

    // One operation word waiting to be driven
    typedef struct {
        kind_t               kind;
        logic [ID_W-1:0]     id;
        logic [STATUS_W-1:0] status;
        int                  gap_after;
        bit                  drain_first;
    } op_t;

    // One result word as the queue should report it
    typedef struct {
        outcome_t            outcome;
        logic                pop_valid;
        logic [ID_W-1:0]     id;
        logic [STATUS_W-1:0] status;
        logic [OCC_W-1:0]    occupancy;
    } rpt_t;

    logic clk;
    logic rst_n;

    derq_in_if  evt_in ();
    derq_out_if rpt_out ();

    dedup_event_report_queue_core #(
        .QUEUE_DEPTH(QDEPTH)
    ) u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .evt_in  (evt_in.sink),
        .rpt_out (rpt_out.source)
    );

    op_t  pending_ops[$];
    rpt_t expected_rpts[$];

    // Shadow copy of the queue contents
    logic [ID_W-1:0]     model_ids[QDEPTH];
    logic [STATUS_W-1:0] model_statuses[QDEPTH];
    int                  model_count;

    int  mismatches;
    bit  in_taken;
    int  send_gap;
    int  ready_hold;

    // Clock: 12 ns period
    initial clk = 1'b0;
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Apply one operation to the shadow queue and return the expected result
    function automatic rpt_t queue_model_step(kind_t kind, logic [ID_W-1:0] id,
                                              logic [STATUS_W-1:0] status);
        rpt_t r;
        bit   hit;
        r.outcome   = OUT_NONE;
        r.pop_valid = 1'b0;
        r.id        = '0;
        r.status    = '0;
        hit         = 1'b0;
        if (kind == KIND_PUSH)
        begin
            for (int k = 0; k < model_count; k++)
                if (model_ids[k] == id)
                    hit = 1'b1;
            if (hit)
                r.outcome = OUT_DUP;
            else if (model_count >= QDEPTH)
                r.outcome = OUT_FULL;
            else
            begin
                model_ids[model_count]      = id;
                model_statuses[model_count] = status;
                model_count++;
                r.outcome = OUT_STORED;
            end
        end
        else if (model_count > 0)
        begin
            r.pop_valid = 1'b1;
            r.id        = model_ids[0];
            r.status    = model_statuses[0];
            for (int k = 0; k + 1 < model_count; k++)
            begin
                model_ids[k]      = model_ids[k + 1];
                model_statuses[k] = model_statuses[k + 1];
            end
            model_count--;
        end
        r.occupancy = OCC_W'(model_count);
        return r;
    endfunction

    // Print one mismatch line and count it
    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        mismatches++;
        if (mismatches <= MAX_PRINTS)
            $display("%0t ns: mismatch on %s: got 0x%0h, expected 0x%0h",
                     $realtime, what, got, want);
    endtask

    task automatic add_op(kind_t kind, logic [ID_W-1:0] id, logic [STATUS_W-1:0] status,
                          int gap_after, bit drain_first);
        op_t o;
        o.kind        = kind;
        o.id          = id;
        o.status      = status;
        o.gap_after   = gap_after;
        o.drain_first = drain_first;
        pending_ops.push_back(o);
    endtask

    // Mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 30);
    endfunction

    // Driver: present the next word at the falling edge, hold it until taken
    always @(negedge clk)
    begin
        op_t o;
        if (rst_n)
        begin
            if (!evt_in.valid || in_taken)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    evt_in.valid <= 1'b0;
                end
                else if (pending_ops.size() > 0 &&
                         (!pending_ops[0].drain_first || expected_rpts.size() == 0))
                begin
                    o = pending_ops.pop_front();
                    evt_in.kind         <= o.kind;
                    evt_in.event_id     <= o.id;
                    evt_in.event_status <= o.status;
                    evt_in.valid        <= 1'b1;
                    send_gap = o.gap_after;
                end
                else
                    evt_in.valid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls on ready, long high stretches too
    always @(negedge clk)
    begin
        int r;
        if (rst_n)
        begin
            if (ready_hold > 0)
                ready_hold--;
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 65)
                begin
                    rpt_out.ready <= 1'b1;
                    ready_hold = $urandom_range(1, 40);
                end
                else if (r < 95)
                begin
                    rpt_out.ready <= 1'b0;
                    ready_hold = $urandom_range(0, 3);
                end
                else
                begin
                    rpt_out.ready <= 1'b0;
                    ready_hold = $urandom_range(10, 30);
                end
            end
        end
    end

    // Monitor: check the result word taken, then predict for the operation taken
    always @(posedge clk)
    begin
        rpt_t want;
        if (rst_n)
        begin
            if (rpt_out.valid && rpt_out.ready)
            begin
                if (expected_rpts.size() == 0)
                    report_mismatch("unexpected result word", {28'd0, rpt_out.occupancy}, 0);
                else
                begin
                    want = expected_rpts.pop_front();
                    if (rpt_out.push_outcome !== want.outcome)
                        report_mismatch("push_outcome", rpt_out.push_outcome, want.outcome);
                    if (rpt_out.pop_valid !== want.pop_valid)
                        report_mismatch("pop_valid", rpt_out.pop_valid, want.pop_valid);
                    if (rpt_out.out_event_id !== want.id)
                        report_mismatch("out_event_id", rpt_out.out_event_id, want.id);
                    if (rpt_out.out_event_status !== want.status)
                        report_mismatch("out_event_status", rpt_out.out_event_status,
                                        want.status);
                    if (rpt_out.occupancy !== want.occupancy)
                        report_mismatch("occupancy", rpt_out.occupancy, want.occupancy);
                end
            end
            if (evt_in.valid && evt_in.ready)
                expected_rpts.push_back(queue_model_step(kind_t'(evt_in.kind),
                                                         evt_in.event_id,
                                                         evt_in.event_status));
            in_taken <= evt_in.valid && evt_in.ready;
        end
    end

    // Run limit
    initial
    begin
        #10ms;
        $display("== FAIL ==");
        $finish;
    end

    // Stimulus and end of run
    initial
    begin
        logic [ID_W-1:0] id_pool[12];
        int              push_pct;
        bit              calm;
        int              g;

        rst_n                = 1'b0;
        evt_in.valid         = 1'b0;
        evt_in.kind          = KIND_PUSH;
        evt_in.event_id      = '0;
        evt_in.event_status  = '0;
        rpt_out.ready        = 1'b0;
        mismatches           = 0;
        in_taken             = 1'b0;
        send_gap             = 0;
        ready_hold           = 0;
        model_count          = 0;
        for (int k = 0; k < QDEPTH; k++)
        begin
            model_ids[k]      = '0;
            model_statuses[k] = '0;
        end

        // Directed: pop on empty, id and status extremes, duplicate, full, drain
        add_op(KIND_POP,  16'h0000, 8'h00, 0, 1'b0);
        add_op(KIND_PUSH, 16'h0000, 8'h00, 0, 1'b0);
        add_op(KIND_PUSH, 16'hFFFF, 8'hFF, 1, 1'b0);
        add_op(KIND_PUSH, 16'hFFFF, 8'h00, 0, 1'b0);
        add_op(KIND_PUSH, 16'h8000, 8'h80, 0, 1'b0);
        add_op(KIND_PUSH, 16'h5555, 8'h55, 0, 1'b0);
        add_op(KIND_PUSH, 16'hAAAA, 8'hAA, 2, 1'b0);
        add_op(KIND_PUSH, 16'h00FF, 8'h0F, 0, 1'b0);
        add_op(KIND_PUSH, 16'hFF00, 8'hF0, 0, 1'b0);
        add_op(KIND_PUSH, 16'h1234, 8'h01, 0, 1'b0);
        add_op(KIND_PUSH, 16'h4321, 8'hFE, 0, 1'b0);
        add_op(KIND_PUSH, 16'h5555, 8'h00, 0, 1'b0);
        add_op(KIND_PUSH, 16'h1234, 8'h7F, 0, 1'b0);
        for (int k = 0; k < QDEPTH + 1; k++)
            add_op(KIND_POP, 16'hFFFF, 8'hFF, 0, k == 0);

        // Random: mixes of push rate, ids mostly from a small pool for duplicates
        push_pct = 60;
        calm     = 1'b0;
        for (int n = 0; n < 1650; n++)
        begin
            if (n % 200 == 0)
                for (int k = 0; k < 12; k++)
                    id_pool[k] = ($urandom_range(0, 9) == 0) ? 16'hFFFF : 16'($urandom);
            if (n % 40 == 0)
            begin
                case ($urandom_range(0, 2))
                    0: push_pct = 80;
                    1: push_pct = 50;
                    default: push_pct = 30;
                endcase
                calm = ($urandom_range(0, 3) == 0);
            end
            g = calm ? 0 : pick_gap();
            if ($urandom_range(0, 99) < push_pct)
            begin
                if ($urandom_range(0, 99) < 65)
                    add_op(KIND_PUSH, id_pool[$urandom_range(0, 11)], 8'($urandom), g,
                           n % 300 == 150);
                else
                    add_op(KIND_PUSH, 16'($urandom), 8'($urandom), g, n % 300 == 150);
            end
            else
                add_op(KIND_POP, 16'($urandom), 8'($urandom), g, n % 300 == 150);
        end

        // Release reset at a falling edge
        repeat (5) @(negedge clk);
        rst_n = 1'b1;

        // Wait for all words taken and all results checked
        while (pending_ops.size() != 0 || evt_in.valid || expected_rpts.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);

        if (mismatches == 0 && expected_rpts.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
